// ----- rtl/bai_pkg.sv -----
// Shared types and constants for the box-average image resizer.
// Used by bai_div, box_average_image_resizer, bai_pixel_checker and the testbench; no dependencies.
`default_nettype none
package bai_pkg;

    localparam int MAX_SRC_WIDTH  = 1024;
    localparam int MAX_SRC_HEIGHT = 1024;
    localparam int MAX_DST_WIDTH  = 1024;
    localparam int MAX_DST_HEIGHT = 1024;

    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;
    localparam int PIX_W   = 24;
    localparam int SUM_W   = 28;
    localparam int CNT_W   = 21;
    localparam int TOTAL_W = 30;
    localparam int SRC_AW  = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int PREV_AW = $clog2(MAX_DST_HEIGHT);

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_REGION_WIDTH  = 3'd2,
        REG_REGION_HEIGHT = 3'd3,
        REG_DST_WIDTH     = 3'd4,
        REG_DST_HEIGHT    = 3'd5,
        REG_HALFTONE      = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        CS_NX = 3'd0,
        CS_NY = 3'd1,
        CS_XE = 3'd2,
        CS_YE = 3'd3,
        CS_LX = 3'd4
    } coord_step_t;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_MUL    = 11'b000_0000_0010,
        ST_START  = 11'b000_0000_0100,
        ST_DIV    = 11'b000_0000_1000,
        ST_BOX    = 11'b000_0001_0000,
        ST_NEAR   = 11'b000_0010_0000,
        ST_NEAR_W = 11'b000_0100_0000,
        ST_UP_W   = 11'b000_1000_0000,
        ST_AVG    = 11'b001_0000_0000,
        ST_AVG_W  = 11'b010_0000_0000,
        ST_FIN    = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/bai_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module bai_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bai_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by coordinate and average math.
// Depends on bai_pkg.
`default_nettype none
module bai_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bai_pkg::div_req_t  req,
    output logic                    done,
    output logic [bai_pkg::SUM_W-1:0] quotient
);
    import bai_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- rtl/box_average_image_resizer.sv -----
// Top level of the box-average image resizer: config port, sequencer, frame stores.
// Depends on bai_pkg, bai_ram and bai_div.
//
// Usage: the slave stream carries load and emit beats, tuser selects which (0 load,
// 1 emit). A load beat writes one BGR pixel into the 1024x1024 frame store. An emit
// beat produces the next output pixel, column-major, on the master stream with tlast
// on the final pixel of the frame; emits after that give no beat. Work per emit:
// nearest mode does two coordinate divisions, a store read and the output step. Box
// mode does five coordinate divisions, one store read per box pixel and three
// channel divisions; an empty box falls back to the nearest pixel, blended with its
// neighbors, before the three channel divisions. All divisions use the shared
// 28-step divider. One item is worked on at a time; the next is accepted as soon
// as the result has moved to the output register, even if the receiver has not
// taken it yet. A stalled receiver holds the output register and the sequencer
// waits in its final step. Reset clears position, running total and the frame-done
// flag and loads the register defaults; the frame stores are not cleared and must
// be loaded before they are read. Registers must be written over APB only while
// idle; the block itself does not enforce this.
`default_nettype none
module box_average_image_resizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // src_x[9:0], src_y[19:10], in_blue[27:20], in_green[35:28], in_red[43:36]
    input  wire logic [47:0] s_tdata,
    // mode[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_x[9:0], out_y[19:10], out_blue[27:20], out_green[35:28], out_red[43:36],
    // byte_total[73:44]
    output logic [79:0]      m_tdata,
    output logic             m_tlast
);
    import bai_pkg::*;

    localparam int OUT_W = 74;

    logic [SIZE_W-1:0] iw_cfg_reg, ih_cfg_reg, rw_cfg_reg, rh_cfg_reg, dw_cfg_reg, dh_cfg_reg;
    logic              halftone_reg;
    logic [SIZE_W-1:0] iw, ih, rw, rh, dw, dh, xl, yl;
    logic              cfg_we;

    state_t               state_reg, state_next;
    logic [2:0]           k_reg, k_next;
    logic [1:0]           ch_reg, ch_next;
    logic [SIZE_W-1:0]    x_reg, x_next;
    logic [COORD_W-1:0]   y_reg, y_next;
    logic [SIZE_W-1:0]    col_reg, col_next;
    logic [COORD_W-1:0]   row_reg, row_next;
    logic [SIZE_W-1:0]    nx_reg, nx_next, ny_reg, ny_next, xe_reg, xe_next;
    logic [SIZE_W-1:0]    ye_reg, ye_next, lx_reg, lx_next;
    logic [SIZE_W-1:0]    sx_reg, sx_next, sy_reg, sy_next;
    logic                 pend_reg, pend_next;
    logic [2:0][SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [PIX_W-1:0]     pix_reg, pix_next;
    logic [2*SIZE_W-1:0]  prod_reg, prod_next;
    logic                 finished_reg, finished_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 accept;
    logic                 row_wrap;
    logic [SIZE_W-1:0]    col_cur;
    logic [SIZE_W-1:0]    mul_a, mul_b;
    logic                 k_is_row;
    logic [SIZE_W:0]      sy_inc;
    logic [SIZE_W-1:0]    row_inc;
    logic                 box_issue;
    logic                 out_free;
    logic [9:0]           byte_sum;
    logic [TOTAL_W-1:0]   total_new;

    logic                 src_we, src_re, prev_we, prev_re;
    logic [SRC_AW-1:0]    src_waddr, src_raddr;
    logic [PIX_W-1:0]     src_wdata, src_rdata, prev_rdata;
    logic [PREV_AW-1:0]   prev_raddr;
    div_req_t             div_req;
    logic                 div_done;
    logic [SUM_W-1:0]     div_quo;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_cfg_reg   <= SIZE_W'(1024);
            ih_cfg_reg   <= SIZE_W'(1024);
            rw_cfg_reg   <= SIZE_W'(1024);
            rh_cfg_reg   <= SIZE_W'(1024);
            dw_cfg_reg   <= SIZE_W'(1024);
            dh_cfg_reg   <= SIZE_W'(1024);
            halftone_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_IMAGE_WIDTH:   iw_cfg_reg   <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  ih_cfg_reg   <= pwdata[SIZE_W-1:0];
                REG_REGION_WIDTH:  rw_cfg_reg   <= pwdata[SIZE_W-1:0];
                REG_REGION_HEIGHT: rh_cfg_reg   <= pwdata[SIZE_W-1:0];
                REG_DST_WIDTH:     dw_cfg_reg   <= pwdata[SIZE_W-1:0];
                REG_DST_HEIGHT:    dh_cfg_reg   <= pwdata[SIZE_W-1:0];
                REG_HALFTONE:      halftone_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_IMAGE_WIDTH:   prdata = 32'(iw_cfg_reg);
            REG_IMAGE_HEIGHT:  prdata = 32'(ih_cfg_reg);
            REG_REGION_WIDTH:  prdata = 32'(rw_cfg_reg);
            REG_REGION_HEIGHT: prdata = 32'(rh_cfg_reg);
            REG_DST_WIDTH:     prdata = 32'(dw_cfg_reg);
            REG_DST_HEIGHT:    prdata = 32'(dh_cfg_reg);
            REG_HALFTONE:      prdata = 32'(halftone_reg);
            default:           prdata = '0;
        endcase
    end

    assign iw = clamp_size(iw_cfg_reg, SIZE_W'(MAX_SRC_WIDTH));
    assign ih = clamp_size(ih_cfg_reg, SIZE_W'(MAX_SRC_HEIGHT));
    assign rw = clamp_size(rw_cfg_reg, SIZE_W'(MAX_SRC_WIDTH));
    assign rh = clamp_size(rh_cfg_reg, SIZE_W'(MAX_SRC_HEIGHT));
    assign dw = clamp_size(dw_cfg_reg, SIZE_W'(MAX_DST_WIDTH));
    assign dh = clamp_size(dh_cfg_reg, SIZE_W'(MAX_DST_HEIGHT));
    assign xl = (xe_reg < iw) ? xe_reg : iw;
    assign yl = (ye_reg < ih) ? ye_reg : ih;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign row_wrap = {1'b0, row_reg} >= dh;
    assign col_cur  = row_wrap ? col_reg + SIZE_W'(1) : col_reg;
    assign k_is_row = (k_reg == CS_NY) || (k_reg == CS_YE);
    assign sy_inc   = {1'b0, sy_reg} + (SIZE_W+1)'(1);
    assign row_inc  = {1'b0, y_reg} + SIZE_W'(1);
    assign box_issue = (sx_reg < xl) && (sy_reg < yl);
    assign byte_sum = 10'(pix_reg[7:0]) + 10'(pix_reg[15:8]) + 10'(pix_reg[23:16]);
    assign total_new = total_reg + TOTAL_W'(byte_sum);

    always_comb
    begin
        unique case (k_reg)
            CS_NX:
            begin
                mul_a = x_reg;
                mul_b = rw;
            end
            CS_NY:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = rh;
            end
            CS_XE:
            begin
                mul_a = x_reg + SIZE_W'(1);
                mul_b = rw;
            end
            CS_YE:
            begin
                mul_a = {1'b0, y_reg} + SIZE_W'(1);
                mul_b = rh;
            end
            default:
            begin
                mul_a = x_reg - SIZE_W'(1);
                mul_b = rw;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        ch_next        = ch_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        xe_next        = xe_reg;
        ye_next        = ye_reg;
        lx_next        = lx_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        pend_next      = 1'b0;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        pix_next       = pix_reg;
        prod_next      = prod_reg;
        finished_next  = finished_reg;
        total_next     = total_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        src_we         = 1'b0;
        src_waddr      = {s_tdata[19:10], s_tdata[9:0]};
        src_wdata      = {s_tdata[43:36], s_tdata[35:28], s_tdata[27:20]};
        src_re         = 1'b0;
        src_raddr      = {ny_reg[COORD_W-1:0], nx_reg[COORD_W-1:0]};
        prev_re        = 1'b0;
        prev_raddr     = y_reg;
        prev_we        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = 28'(prod_reg);
        div_req.divisor  = k_is_row ? 21'(dh) : 21'(dw);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!s_tuser)
                    begin
                        src_we = 1'b1;
                    end
                    else if (!finished_reg)
                    begin
                        if (row_wrap)
                        begin
                            row_next = '0;
                            col_next = col_cur;
                        end
                        if (col_cur >= dw)
                        begin
                            finished_next = 1'b1;
                        end
                        else
                        begin
                            x_next     = col_cur;
                            y_next     = row_wrap ? '0 : row_reg;
                            k_next     = CS_NX;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = {11'b0, mul_a} * {11'b0, mul_b};
                state_next = ST_START;
            end
            ST_START:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    unique case (k_reg)
                        CS_NX:   nx_next = div_quo[SIZE_W-1:0];
                        CS_NY:   ny_next = div_quo[SIZE_W-1:0];
                        CS_XE:   xe_next = div_quo[SIZE_W-1:0];
                        CS_YE:   ye_next = div_quo[SIZE_W-1:0];
                        default: lx_next = div_quo[SIZE_W-1:0];
                    endcase
                    if (!halftone_reg && k_reg == CS_NY)
                    begin
                        state_next = ST_NEAR;
                    end
                    else if (k_reg == CS_LX)
                    begin
                        sx_next    = nx_reg;
                        sy_next    = ny_reg;
                        sum_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_BOX;
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_BOX:
            begin
                src_raddr = {sy_reg[COORD_W-1:0], sx_reg[COORD_W-1:0]};
                if (pend_reg)
                begin
                    sum_next[0] = sum_reg[0] + SUM_W'(src_rdata[7:0]);
                    sum_next[1] = sum_reg[1] + SUM_W'(src_rdata[15:8]);
                    sum_next[2] = sum_reg[2] + SUM_W'(src_rdata[23:16]);
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                if (box_issue)
                begin
                    src_re    = 1'b1;
                    pend_next = 1'b1;
                    if (sy_inc >= {1'b0, yl})
                    begin
                        sy_next = ny_reg;
                        sx_next = sx_reg + SIZE_W'(1);
                    end
                    else
                    begin
                        sy_next = sy_inc[SIZE_W-1:0];
                    end
                end
                else if (!pend_reg)
                begin
                    ch_next    = '0;
                    state_next = (cnt_reg == '0) ? ST_NEAR : ST_AVG;
                end
            end
            ST_NEAR:
            begin
                src_re     = 1'b1;
                prev_re    = 1'b1;
                state_next = ST_NEAR_W;
            end
            ST_NEAR_W:
            begin
                pix_next    = src_rdata;
                sum_next[0] = SUM_W'(src_rdata[7:0]);
                sum_next[1] = SUM_W'(src_rdata[15:8]);
                sum_next[2] = SUM_W'(src_rdata[23:16]);
                cnt_next    = CNT_W'(1);
                if (x_reg != '0 && nx_reg == lx_reg)
                begin
                    sum_next[0] = SUM_W'(src_rdata[7:0]) + SUM_W'(prev_rdata[7:0]);
                    sum_next[1] = SUM_W'(src_rdata[15:8]) + SUM_W'(prev_rdata[15:8]);
                    sum_next[2] = SUM_W'(src_rdata[23:16]) + SUM_W'(prev_rdata[23:16]);
                    cnt_next    = CNT_W'(2);
                end
                prev_re    = 1'b1;
                prev_raddr = y_reg - COORD_W'(1);
                state_next = halftone_reg ? ST_UP_W : ST_FIN;
            end
            ST_UP_W:
            begin
                if (y_reg != '0 && ny_reg == ye_reg)
                begin
                    sum_next[0] = sum_reg[0] + SUM_W'(prev_rdata[7:0]);
                    sum_next[1] = sum_reg[1] + SUM_W'(prev_rdata[15:8]);
                    sum_next[2] = sum_reg[2] + SUM_W'(prev_rdata[23:16]);
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                ch_next    = '0;
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_reg[ch_reg];
                div_req.divisor  = cnt_reg;
                state_next       = ST_AVG_W;
            end
            ST_AVG_W:
            begin
                if (div_done)
                begin
                    pix_next[ch_reg*8 +: 8] = div_quo[7:0];
                    if (ch_reg == 2'd2)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_AVG;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    prev_we        = 1'b1;
                    total_next     = total_new;
                    out_valid_next = 1'b1;
                    out_data_next  = {total_new, pix_reg, y_reg, x_reg[COORD_W-1:0]};
                    out_last_next  = (x_reg == dw - SIZE_W'(1)) &&
                                     ({1'b0, y_reg} == dh - SIZE_W'(1));
                    if (out_last_next)
                    begin
                        finished_next = 1'b1;
                    end
                    if (row_inc >= dh)
                    begin
                        row_next = '0;
                        col_next = x_reg + SIZE_W'(1);
                    end
                    else
                    begin
                        row_next = row_inc[COORD_W-1:0];
                        col_next = x_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            total_reg     <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            total_reg     <= total_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        ch_reg       <= ch_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        xe_reg       <= xe_next;
        ye_reg       <= ye_next;
        lx_reg       <= lx_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        pix_reg      <= pix_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_data_reg};
    assign m_tlast  = out_last_reg;

    bai_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
    ) u_src_ram (
        .clk  (clk),
        .we   (src_we),
        .waddr(src_waddr),
        .wdata(src_wdata),
        .re   (src_re),
        .raddr(src_raddr),
        .rdata(src_rdata)
    );

    bai_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_DST_HEIGHT)
    ) u_prev_ram (
        .clk  (clk),
        .we   (prev_we),
        .waddr(y_reg),
        .wdata(pix_reg),
        .re   (prev_re),
        .raddr(prev_raddr),
        .rdata(prev_rdata)
    );

    bai_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .done    (div_done),
        .quotient(div_quo)
    );

`ifndef SYNTHESIS
    a_avg_nonzero_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_AVG |-> cnt_reg != '0)
        else $error("channel average started with a zero pixel count");

    a_pend_from_box: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_BOX))
        else $error("box read pending outside the box walk");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && out_free |=> m_tvalid && state_reg == ST_IDLE)
        else $error("finished pixel did not reach the output register");

    a_idle_no_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !div_req.start)
        else $error("divider started while idle");
`endif

endmodule
`default_nettype wire

// ----- verif/bai_pixel_checker.sv -----
// Scoreboard for the box-average image resizer: watches APB writes and both streams,
// predicts every output pixel and compares it with the master stream.
// Depends on bai_pkg for register indexes and size limits.
`timescale 1ns / 1ps
module bai_pixel_checker
    import bai_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [79:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        bit [9:0]  x;
        bit [9:0]  y;
        bit [7:0]  blue;
        bit [7:0]  green;
        bit [7:0]  red;
        bit [29:0] total;
        bit        last;
    } out_pixel_t;

    bit [23:0]  frame_mem [int];
    bit [23:0]  row_mem [MAX_DST_HEIGHT];
    bit [10:0]  cfg [0:6];
    int         col_pos;
    int         row_pos;
    bit [29:0]  byte_sum;
    bit         frame_done;
    out_pixel_t pixel_q [$];

    assign pending = pixel_q.size();

    function automatic int fit(bit [10:0] v, int maxv);
        if (v == 0)
        begin
            return 1;
        end
        return (v > maxv) ? maxv : int'(v);
    endfunction

    function automatic bit [23:0] fetch(int x, int y);
        int key;
        key = y * MAX_SRC_WIDTH + x;
        return frame_mem.exists(key) ? frame_mem[key] : 24'h0;
    endfunction

    function automatic void predict_pixel();
        int iw, ih, rw, rh, dw, dh, x, y, nx, ny, xe, ye, cnt;
        int sum [3];
        bit [23:0] pix;
        out_pixel_t o;
        if (frame_done)
        begin
            return;
        end
        iw = fit(cfg[REG_IMAGE_WIDTH], MAX_SRC_WIDTH);
        ih = fit(cfg[REG_IMAGE_HEIGHT], MAX_SRC_HEIGHT);
        rw = fit(cfg[REG_REGION_WIDTH], MAX_SRC_WIDTH);
        rh = fit(cfg[REG_REGION_HEIGHT], MAX_SRC_HEIGHT);
        dw = fit(cfg[REG_DST_WIDTH], MAX_DST_WIDTH);
        dh = fit(cfg[REG_DST_HEIGHT], MAX_DST_HEIGHT);
        if (row_pos >= dh)
        begin
            row_pos = 0;
            col_pos++;
        end
        if (col_pos >= dw)
        begin
            frame_done = 1;
            return;
        end
        x = col_pos;
        y = row_pos;
        nx = x * rw / dw;
        ny = y * rh / dh;
        if (cfg[REG_HALFTONE][0])
        begin
            xe = (x + 1) * rw / dw;
            ye = (y + 1) * rh / dh;
            cnt = 0;
            sum = '{0, 0, 0};
            for (int sx = nx; sx < xe; sx++)
            begin
                for (int sy = ny; sy < ye; sy++)
                begin
                    if (sx < iw && sy < ih)
                    begin
                        pix = fetch(sx, sy);
                        cnt++;
                        for (int k = 0; k < 3; k++) sum[k] += pix[8*k +: 8];
                    end
                end
            end
            // An empty box falls back to the nearest pixel blended with its neighbors.
            if (cnt == 0)
            begin
                pix = fetch(nx, ny);
                cnt = 1;
                for (int k = 0; k < 3; k++) sum[k] = pix[8*k +: 8];
                if (x != 0 && nx == (x - 1) * rw / dw)
                begin
                    pix = row_mem[y];
                    cnt++;
                    for (int k = 0; k < 3; k++) sum[k] += pix[8*k +: 8];
                end
                if (y != 0 && ny == ye)
                begin
                    pix = row_mem[y - 1];
                    cnt++;
                    for (int k = 0; k < 3; k++) sum[k] += pix[8*k +: 8];
                end
            end
            for (int k = 0; k < 3; k++) pix[8*k +: 8] = 8'(sum[k] / cnt);
        end
        else
        begin
            pix = fetch(nx, ny);
        end
        row_mem[y] = pix;
        byte_sum = byte_sum + pix[7:0] + pix[15:8] + pix[23:16];
        o.x = 10'(x);
        o.y = 10'(y);
        o.blue = pix[7:0];
        o.green = pix[15:8];
        o.red = pix[23:16];
        o.total = byte_sum;
        o.last = (x == dw - 1 && y == dh - 1);
        if (o.last)
        begin
            frame_done = 1;
        end
        pixel_q.push_back(o);
        row_pos++;
        if (row_pos >= dh)
        begin
            row_pos = 0;
            col_pos++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_pixel_t got, want;
        if (!rst_n)
        begin
            col_pos = 0;
            row_pos = 0;
            byte_sum = '0;
            frame_done = 0;
            for (int i = 0; i < 6; i++) cfg[i] = 11'd1024;
            cfg[REG_HALFTONE] = '0;
            pixel_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[9:0], m_tdata[19:10], m_tdata[27:20], m_tdata[35:28],
                       m_tdata[43:36], m_tdata[73:44], m_tlast};
                if (pixel_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output beat: %p", got);
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("pixel mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr[4:2] <= REG_HALFTONE)
            begin
                cfg[paddr[4:2]] = pwdata[10:0];
            end
            if (s_tvalid && s_tready)
            begin
                if (!s_tuser)
                    frame_mem[int'(s_tdata[19:10]) * MAX_SRC_WIDTH + int'(s_tdata[9:0])] =
                        s_tdata[43:20];
                else
                    predict_pixel();
            end
        end
    end

endmodule

// ----- verif/tb_box_average_image_resizer.sv -----
// Testbench top for the box-average image resizer: clock, reset, APB setup,
// load and emit stimulus with random gaps and back-pressure, and the verdict.
// Depends on bai_pkg, the resizer RTL and bai_pixel_checker.
`timescale 1ns / 1ps
module tb_box_average_image_resizer;
    import bai_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int BASE_SIZE = 24;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 1;
    logic [79:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    bit          hold_req = 0;
    int          idle_cycles = 0;

    // Output position and effective sizes, tracked to aim loads and to avoid
    // ending the frame early. Box mode is used only where every output row that
    // a neighbor blend can read has been produced at least once.
    int col = 0, row = 0;
    int rows_seen = 0;
    int eff_rw = 1024, eff_rh = 1024, eff_dw = 1024, eff_dh = 1024;
    bit wide_region = 0;

    box_average_image_resizer dut (.*);

    bai_pixel_checker u_checker (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int r;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 0;
                repeat (600) @(negedge clk);
                hold_req = 0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    m_tready = 1;
                else
                begin
                    m_tready = 0;
                    repeat (r < 95 ? $urandom_range(0, 2) : $urandom_range(20, 60))
                        @(negedge clk);
                end
            end
        end
    end

    function automatic int eff(int raw, int maxv);
        if (raw == 0)
            return 1;
        return (raw > maxv) ? maxv : raw;
    endfunction

    task automatic set_reg(reg_idx_t idx, int v);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 2'b00};
        pwdata = 32'(v);
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        case (idx)
            REG_REGION_WIDTH:  eff_rw = eff(v, MAX_SRC_WIDTH);
            REG_REGION_HEIGHT: eff_rh = eff(v, MAX_SRC_HEIGHT);
            REG_DST_WIDTH:     eff_dw = eff(v, MAX_DST_WIDTH);
            REG_DST_HEIGHT:    eff_dh = eff(v, MAX_DST_HEIGHT);
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid = 0;
        while (pending != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic reconfigure(int iw, int ih, int rw, int rh, int dw, int dh, int ht);
        drain();
        repeat (900) @(negedge clk);
        set_reg(REG_IMAGE_WIDTH, iw);
        set_reg(REG_IMAGE_HEIGHT, ih);
        set_reg(REG_REGION_WIDTH, rw);
        set_reg(REG_REGION_HEIGHT, rh);
        set_reg(REG_DST_WIDTH, dw);
        set_reg(REG_DST_HEIGHT, dh);
        set_reg(REG_HALFTONE, ht);
    endtask

    task automatic push_beat(bit mode, int sx, int sy, bit [23:0] bgr);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 70)
        begin
            s_tvalid = 0;
            repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk);
        end
        s_tvalid = 1;
        s_tuser = mode;
        s_tdata = {4'b0, bgr, 10'(sy), 10'(sx)};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic emit_pixel();
        int c, rr;
        c = col;
        rr = row;
        if (rr >= eff_dh)
        begin
            rr = 0;
            c++;
        end
        // A wide region reads anywhere in the store, so the nearest pixel is loaded first.
        if (wide_region)
            push_beat(0, c * eff_rw / eff_dw, rr * eff_rh / eff_dh, 24'($urandom));
        push_beat(1, $urandom_range(0, 1023), $urandom_range(0, 1023), 24'($urandom));
        if (rr + 1 > rows_seen)
            rows_seen = rr + 1;
        col = c;
        row = rr + 1;
        if (row >= eff_dh)
        begin
            row = 0;
            col++;
        end
    endtask

    function automatic int pick_image();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 2047;
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    initial
    begin
        int dh, dw, rw, rh, n;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        reconfigure(BASE_SIZE, BASE_SIZE, 8, 8, 0, 5, 0);
        for (int y = 0; y < BASE_SIZE; y++)
            for (int x = 0; x < BASE_SIZE; x++)
                push_beat(0, x, y, 24'($urandom));
        push_beat(0, 1023, 1023, 24'hFFFFFF);
        push_beat(0, 1023, 0, 24'h000000);
        push_beat(0, 0, 0, 24'hFFFFFF);
        repeat (3) emit_pixel();

        reconfigure(0, 2047, BASE_SIZE, BASE_SIZE, 1024, 5, 1);
        repeat (4) emit_pixel();
        reconfigure(BASE_SIZE, BASE_SIZE, 3, 2, 1024, 5, 1);
        repeat (8) emit_pixel();
        wide_region = 1;
        reconfigure(BASE_SIZE, BASE_SIZE, 2047, 1024, 900, 1024, 0);
        repeat (4) emit_pixel();

        for (int p = 0; p < 27; p++)
        begin
            wide_region = ($urandom_range(0, 7) == 0);
            if (col > 700)
                dh = $urandom_range(0, 1) ? 1024 : 2047;
            else
            begin
                case ($urandom_range(0, 9))
                    0: dh = 0;
                    1: dh = 1;
                    9: dh = 1024;
                    default: dh = $urandom_range(2, 9);
                endcase
            end
            dw = ($urandom_range(0, 3) == 0) ? 2047 : col + 62 + $urandom_range(0, 300);
            if (dw > 1024 && dw != 2047)
                dw = 1024;
            rw = wide_region ? ($urandom_range(0, 1) ? 2047 : 1024) : $urandom_range(0, BASE_SIZE);
            rh = wide_region ? ($urandom_range(0, 1) ? 2047 : 1024) : $urandom_range(0, BASE_SIZE);
            reconfigure(pick_image(), pick_image(), rw, rh, dw, dh,
                        (wide_region || eff(dh, MAX_DST_HEIGHT) > rows_seen) ? 0 :
                        $urandom_range(0, 1));
            if (p == 3)
                hold_req = 1;
            n = $urandom_range(30, 60);
            for (int i = 0; i < n; i++)
            begin
                if (p == 10 && i == n / 2)
                    drain();
                case ($urandom_range(0, 9))
                    0: push_beat(0, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                 24'($urandom));
                    1: push_beat(0, $urandom_range(0, BASE_SIZE - 1),
                                 $urandom_range(0, BASE_SIZE - 1), 24'($urandom));
                    default: emit_pixel();
                endcase
            end
        end

        // Close the frame at the current column, then check that further emits are quiet.
        wide_region = 0;
        drain();
        if (row >= eff_dh)
        begin
            row = 0;
            col++;
        end
        dh = (row + 3 > 1024) ? 1024 : row + 3;
        reconfigure(BASE_SIZE, BASE_SIZE, $urandom_range(1, BASE_SIZE),
                    $urandom_range(1, BASE_SIZE), col + 1, dh, (dh <= rows_seen) ? 1 : 0);
        n = eff_dh - row + 3;
        repeat (n) emit_pixel();

        drain();
        repeat (1000) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- box_average_image_resizer.f -----
rtl/bai_pkg.sv
rtl/bai_ram.sv
rtl/bai_div.sv
rtl/box_average_image_resizer.sv
verif/bai_pixel_checker.sv
verif/tb_box_average_image_resizer.sv
